### rtl/core/stereo_sample_fifo_with_underrun_pad_core_macros.svh
// Assertion macros for the stereo sample FIFO core.
// Included by the modules that carry concurrent checks.
`ifndef STEREO_SAMPLE_FIFO_WITH_UNDERRUN_PAD_CORE_MACROS_SVH
`define STEREO_SAMPLE_FIFO_WITH_UNDERRUN_PAD_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSF_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/ssf_pkg.sv
// Shared types, constants and helpers for the stereo sample FIFO core.
// No dependencies.
package ssf_pkg;

  localparam int MAX_FRAMES_DEF  = 4096;
  localparam int MAX_REQUEST_DEF = 64;

  localparam int BATCH_W  = 13;
  localparam int SAMPLE_W = 16;
  localparam int REQ_F_W  = 7;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_PULL
  } back_state_t;

  typedef struct packed {
    op_t                  op;
    logic                 batch_start;
    logic [BATCH_W-1:0]   batch_frames;
    logic [SAMPLE_W-1:0]  left;
    logic [SAMPLE_W-1:0]  right;
    logic [REQ_F_W-1:0]   req_n;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [31:0] x);
    logic [SAMPLE_W-1:0] r;
    if (x > 32'sd32767) begin
      r = 16'h7fff;
    end else if (x < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/ssf_front.sv
// Front end: accepts input requests, saturates samples, clamps pull length.
// Depends on ssf_pkg.
module ssf_front #(
  parameter int MAX_REQUEST = ssf_pkg::MAX_REQUEST_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic               batch_start,
  input  logic [12:0]        batch_frames,
  input  logic signed [31:0] left_in,
  input  logic signed [31:0] right_in,
  input  logic [6:0]         request_frames,
  input  ssf_pkg::q_status_t q_status,
  output logic               q_push,
  output ssf_pkg::cmd_t      q_cmd
);
  import ssf_pkg::*;

  logic [REQ_F_W-1:0] req_clamped;
  logic               keep;

  assign req_clamped = (request_frames > REQ_F_W'(MAX_REQUEST)) ?
                       REQ_F_W'(MAX_REQUEST) : request_frames;

  // drop empty pulls here: they yield nothing and change nothing
  assign keep = (op_t'(op) == OP_PUSH) || (req_clamped != '0);

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full && keep;

  always_comb begin
    q_cmd.op           = op_t'(op);
    q_cmd.batch_start  = batch_start;
    q_cmd.batch_frames = batch_frames;
    q_cmd.left         = sat16(left_in);
    q_cmd.right        = sat16(right_in);
    q_cmd.req_n        = req_clamped;
  end

endmodule

### rtl/core/ssf_queue.sv
// Short command queue between the front end and the back end.
// Depends on ssf_pkg and the core assertion macros.
`include "stereo_sample_fifo_with_underrun_pad_core_macros.svh"

module ssf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ssf_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output ssf_pkg::cmd_t      head_cmd,
  output ssf_pkg::q_status_t status
);
  import ssf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head_cmd         = entries[rd_ptr];
  assign status.full      = (count == CNT_W'(QUEUE_DEPTH));
  assign status.not_empty = (count != '0);

  `SSF_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, status.not_empty, "pop from empty queue")
  `SSF_ASSERT_NOW(a_no_push_full, clk, rst, push, !status.full, "push into full queue")
  `SSF_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, count != '0, "push lost in queue")

endmodule

### rtl/core/ssf_back.sv
// Back end: frame store, pointers, batch check, pull sequencer, output register.
// Depends on ssf_pkg and the core assertion macros.
`include "stereo_sample_fifo_with_underrun_pad_core_macros.svh"

module ssf_back #(
  parameter int MAX_FRAMES  = ssf_pkg::MAX_FRAMES_DEF,
  parameter int MAX_REQUEST = ssf_pkg::MAX_REQUEST_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ssf_pkg::cmd_t       q_cmd,
  input  ssf_pkg::q_status_t  q_status,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  left_out,
  output logic signed [15:0]  right_out,
  output logic                padded,
  output logic                last,
  output logic [6:0]          delivered_frames,
  output logic [31:0]         underrun_count,
  output logic [11:0]         fill_frames
);
  import ssf_pkg::*;

  localparam int PTR_W  = $clog2(MAX_FRAMES);
  localparam int FILL_W = $clog2(MAX_FRAMES);
  localparam int REQ_W  = $clog2(MAX_REQUEST + 1);
  localparam int CW     = (FILL_W > REQ_W) ? FILL_W : REQ_W;
  localparam int SUM_W  = ((FILL_W > BATCH_W) ? FILL_W : BATCH_W) + 1;
  localparam int FRAME_W = 2 * SAMPLE_W;

  typedef struct packed {
    logic              pad;
    logic              last;
    logic [REQ_W-1:0]  del;
    logic [31:0]       under;
    logic [FILL_W-1:0] fill;
  } meta_t;

  back_state_t state, state_next;

  logic [FRAME_W-1:0] mem [MAX_FRAMES];
  logic [FRAME_W-1:0] rd_data;
  logic [FRAME_W-1:0] last_frame;

  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [FILL_W-1:0] fill;
  logic [31:0]       underrun_counter;
  logic              batch_accepted;

  logic [REQ_W-1:0]  req_n;
  logic [REQ_W-1:0]  req_del;
  logic [FILL_W-1:0] req_fill;
  logic [REQ_W-1:0]  k;

  logic  s1_valid;
  meta_t s1;

  // control decode
  logic              do_push;
  logic              do_start;
  logic              batch_next;
  logic              mem_we;
  logic              s1_move;
  logic              issue;
  logic              issue_pad;
  logic              issue_last;
  logic              mem_re;
  logic [SUM_W-1:0]  batch_sum;
  logic [REQ_W-1:0]  start_n;
  logic [FILL_W-1:0] start_avail;
  logic [REQ_W-1:0]  start_del;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_FRAMES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_status.not_empty && q_cmd.op == OP_PULL) begin
          state_next = BK_PULL;
        end
      end
      BK_PULL: begin
        if (issue && issue_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    do_push  = 1'b0;
    do_start = 1'b0;
    issue    = 1'b0;
    s1_move  = s1_valid && (!out_valid || !out_stall);
    case (state)
      BK_IDLE: begin
        q_pop    = q_status.not_empty;
        do_push  = q_status.not_empty && q_cmd.op == OP_PUSH;
        do_start = q_status.not_empty && q_cmd.op == OP_PULL;
      end
      BK_PULL: begin
        issue = !s1_valid || s1_move;
      end
      default: begin
      end
    endcase
  end

  assign batch_sum  = SUM_W'(q_cmd.batch_frames) + SUM_W'(fill);
  assign batch_next = q_cmd.batch_start ? (batch_sum < SUM_W'(MAX_FRAMES)) : batch_accepted;
  assign mem_we     = do_push && batch_next && (fill != FILL_W'(MAX_FRAMES - 1));

  // one frame always stays behind in the store
  assign start_n     = REQ_W'(q_cmd.req_n);
  assign start_avail = (fill >= FILL_W'(2)) ? fill - FILL_W'(1) : '0;
  assign start_del   = (CW'(start_avail) < CW'(start_n)) ? REQ_W'(start_avail) : start_n;

  assign issue_pad  = (k >= req_del);
  assign issue_last = (k == req_n - REQ_W'(1));
  assign mem_re     = issue && !issue_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= BK_IDLE;
      rp               <= '0;
      wp               <= '0;
      fill             <= '0;
      underrun_counter <= '0;
      batch_accepted   <= 1'b0;
      k                <= '0;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      last_frame       <= '0;
    end else begin
      state <= state_next;
      if (do_push) begin
        batch_accepted <= batch_next;
      end
      if (mem_we) begin
        wp   <= bump(wp);
        fill <= fill + FILL_W'(1);
      end
      if (do_start) begin
        fill <= fill - FILL_W'(start_del);
        k    <= '0;
        if (start_del != start_n) begin
          underrun_counter <= underrun_counter + 32'd1;
        end
      end
      if (issue) begin
        k <= k + REQ_W'(1);
      end
      if (mem_re) begin
        rp <= bump(rp);
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
        if (!s1.pad) begin
          last_frame <= rd_data;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      req_n    <= start_n;
      req_del  <= start_del;
      req_fill <= fill - FILL_W'(start_del);
    end
    if (issue) begin
      s1.pad   <= issue_pad;
      s1.last  <= issue_last;
      s1.del   <= req_del;
      s1.under <= underrun_counter;
      s1.fill  <= req_fill;
    end
  end

  // frame store: left in the upper half, right in the lower half
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= {q_cmd.left, q_cmd.right};
    end
    if (mem_re) begin
      rd_data <= mem[rp];
    end
  end

  // pad with the last frame read, which is the one just behind the read pointer
  always_ff @(posedge clk) begin
    if (s1_move) begin
      left_out         <= s1.pad ? last_frame[FRAME_W-1:SAMPLE_W] : rd_data[FRAME_W-1:SAMPLE_W];
      right_out        <= s1.pad ? last_frame[SAMPLE_W-1:0] : rd_data[SAMPLE_W-1:0];
      padded           <= s1.pad;
      last             <= s1.last;
      delivered_frames <= 7'(s1.del);
      underrun_count   <= s1.under;
      fill_frames      <= 12'(s1.fill);
    end
  end

  `SSF_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_move, s1_valid && $stable(s1), "stage lost")
  `SSF_ASSERT_NEXT(a_pull_end, clk, rst, issue && issue_last, state == BK_IDLE, "pull overran")
  `SSF_ASSERT_NOW(a_no_write_full, clk, rst, mem_we, fill != FILL_W'(MAX_FRAMES - 1), "write on full")
  `SSF_ASSERT_NOW(a_read_stored, clk, rst, mem_re, fill != '0 || rp != wp, "read past write ptr")

endmodule

### rtl/core/stereo_sample_fifo_with_underrun_pad_core.sv
// Top level of the stereo sample FIFO with underrun padding.
// Depends on ssf_pkg, ssf_front, ssf_queue and ssf_back.
//
//   channel | side | handshake            | payload
//   --------+------+----------------------+-----------------------------------------
//   in      | sink | in_valid / in_stall  | op, batch_start, batch_frames, left_in,
//           |      |                      | right_in, request_frames
//   out     | src  | out_valid / out_stall| left_out, right_out, padded, last,
//           |      |                      | delivered_frames, underrun_count, fill_frames
//
// A push is handled in the idle state; a pull issues one frame per cycle while the output
// is not stalled, through the single read port of the frame store.
// Reset clears pointers, fill and counters; the store itself is not swept, since
// padding comes from a register that holds the last frame read (zero after reset).
// A two-entry command queue lets input keep flowing while the output is stalled.
module stereo_sample_fifo_with_underrun_pad_core #(
  parameter int MAX_FRAMES  = ssf_pkg::MAX_FRAMES_DEF,
  parameter int MAX_REQUEST = ssf_pkg::MAX_REQUEST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic               batch_start,
  input  logic [12:0]        batch_frames,
  input  logic signed [31:0] left_in,
  input  logic signed [31:0] right_in,
  input  logic [6:0]         request_frames,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic               padded,
  output logic               last,
  output logic [6:0]         delivered_frames,
  output logic [31:0]        underrun_count,
  output logic [11:0]        fill_frames
);
  import ssf_pkg::*;

  q_status_t q_status;
  cmd_t      front_cmd;
  cmd_t      head_cmd;
  logic      q_push;
  logic      q_pop;

  ssf_front #(
    .MAX_REQUEST(MAX_REQUEST)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .batch_start   (batch_start),
    .batch_frames  (batch_frames),
    .left_in       (left_in),
    .right_in      (right_in),
    .request_frames(request_frames),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_cmd         (front_cmd)
  );

  ssf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(front_cmd),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .status  (q_status)
  );

  ssf_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_REQUEST(MAX_REQUEST)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_cmd           (head_cmd),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .left_out        (left_out),
    .right_out       (right_out),
    .padded          (padded),
    .last            (last),
    .delivered_frames(delivered_frames),
    .underrun_count  (underrun_count),
    .fill_frames     (fill_frames)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stereo_sample_fifo_with_underrun_pad_core.
// Depends on ssf_pkg and the core RTL; holds its own frame-store predictor.
module tb;
  import ssf_pkg::*;

  localparam int RING_SLOTS   = 2 * MAX_FRAMES_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 200;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               pad;
    logic               fin;
    logic [6:0]         delivered;
    logic [31:0]        underruns;
    logic [11:0]        fill;
  } frame_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_PUSH;
  logic               batch_start = 1'b0;
  logic [12:0]        batch_frames = '0;
  logic signed [31:0] left_in = '0;
  logic signed [31:0] right_in = '0;
  logic [6:0]         request_frames = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               padded;
  logic               last;
  logic [6:0]         delivered_frames;
  logic [31:0]        underrun_count;
  logic [11:0]        fill_frames;

  // predictor state
  logic [15:0] ring [RING_SLOTS];
  logic [12:0] rd_idx = '0;
  logic [12:0] wr_idx = '0;
  logic [31:0] underruns = '0;
  bit          batch_open = 1'b0;
  frame_t      expected_frames[$];

  int fail_count = 0;
  int effective_items = 0;
  int pulls_sent = 0;
  int frames_checked = 0;
  int padded_checked = 0;
  int input_stall_cycles = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_granted = 0;
  int hold_left = 0;

  stereo_sample_fifo_with_underrun_pad_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .batch_start(batch_start), .batch_frames(batch_frames),
    .left_in(left_in), .right_in(right_in), .request_frames(request_frames),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_out(left_out), .right_out(right_out), .padded(padded), .last(last),
    .delivered_frames(delivered_frames), .underrun_count(underrun_count),
    .fill_frames(fill_frames)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] clamp_sample(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'h7fff;
    if (v < -32'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int stored_frames();
    logic [12:0] diff;
    diff = wr_idx - rd_idx;
    return int'(diff >> 1);
  endfunction

  // Update the store model with one accepted request and queue its frames.
  task automatic predict_request(input logic is_pull, input logic first,
                                 input logic [12:0] blen, input logic [31:0] l,
                                 input logic [31:0] r, input logic [6:0] req);
    int          fill, n, avail, dlv, k;
    logic [12:0] back_idx;
    logic [15:0] lv, rv;
    frame_t      f;
    fill = stored_frames();
    if (!is_pull) begin
      if (first) batch_open = (int'(blen) + fill) < MAX_FRAMES_DEF;
      if (batch_open && fill + 1 < MAX_FRAMES_DEF) begin
        ring[wr_idx] = clamp_sample(l);
        ring[wr_idx + 13'd1] = clamp_sample(r);
        wr_idx = wr_idx + 13'd2;
        effective_items++;
      end
      return;
    end
    n = (int'(req) > MAX_REQUEST_DEF) ? MAX_REQUEST_DEF : int'(req);
    if (n == 0) return;
    effective_items++;
    pulls_sent++;
    avail = (fill >= 2) ? fill - 1 : 0;
    dlv = (avail < n) ? avail : n;
    if (dlv < n) underruns = underruns + 32'd1;
    lv = '0;
    rv = '0;
    for (k = 0; k < n; k++) begin
      if (k < dlv) begin
        lv = ring[rd_idx];
        rv = ring[rd_idx + 13'd1];
        rd_idx = rd_idx + 13'd2;
      end else if (k == dlv) begin
        // pad with the frame just behind the read side
        back_idx = rd_idx - 13'd2;
        lv = ring[back_idx];
        rv = ring[back_idx + 13'd1];
      end
      f.left = lv;
      f.right = rv;
      f.pad = (k >= dlv);
      f.fin = (k + 1 == n);
      f.delivered = dlv[6:0];
      f.underruns = underruns;
      f.fill = 12'(fill - dlv);
      expected_frames.push_back(f);
    end
  endtask

  task automatic send_request(input logic is_pull, input logic first,
                              input logic [12:0] blen, input logic [31:0] l,
                              input logic [31:0] r, input logic [6:0] req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= is_pull ? OP_PULL : OP_PUSH;
    batch_start <= first;
    batch_frames <= blen;
    left_in <= l;
    right_in <= r;
    request_frames <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(is_pull, first, blen, l, r, req);
  endtask

  task automatic send_push(input logic first, input logic [12:0] blen,
                           input logic [31:0] l, input logic [31:0] r);
    send_request(1'b0, first, blen, l, r, 7'($urandom));
  endtask

  // Pull fields not used by the block still carry random content.
  task automatic send_pull(input logic [6:0] req);
    send_request(1'b1, 1'($urandom), 13'($urandom), $urandom, $urandom, req);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65535)) - 32768);
      2: return $urandom_range(1) ? 32'sd32768 + $urandom_range(2) - 1
                                  : -32'sd32769 + $urandom_range(2) - 1;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  task automatic test_reset_padding();
    send_pull(7'd3);
    send_pull(7'd0);
    send_push(1'b0, 13'd5, 32'd1234, -32'sd1234);
    send_pull(7'd1);
    drain();
  endtask

  task automatic test_saturation_and_batches();
    send_push(1'b1, 13'd0, 32'h7fffffff, 32'h80000000);
    send_push(1'b0, 13'd0, 32'sd32767, -32'sd32768);
    send_push(1'b0, 13'd0, 32'sd32768, -32'sd32769);
    send_push(1'b0, 13'd0, -32'sd1, 32'sd0);
    send_pull(7'd2);
    send_push(1'b1, 13'h1fff, 32'sd77, 32'sd88);
    send_push(1'b0, 13'd0, 32'sd99, 32'sd111);
    send_push(1'b1, 13'd4094, 32'h5555aaaa, 32'haaaa5555);
    send_push(1'b1, 13'd4095, 32'sd5, 32'sd6);
    send_pull(7'd1);
    send_pull(7'd127);
    send_pull(7'd64);
    drain();
  endtask

  // Overrun a stated batch, then pull past the store so reads stop one short.
  task automatic test_short_store();
    int k;
    send_push(1'b1, 13'd6, random_sample(), random_sample());
    for (k = 1; k < 8; k++)
      send_push(1'b0, 13'($urandom), random_sample(), random_sample());
    send_pull(7'd64);
    send_push(1'b1, 13'd2, random_sample(), random_sample());
    send_pull(7'd2);
    send_pull(7'd5);
    drain();
  endtask

  task automatic random_traffic(input int target);
    int start, len, frames, k, choice;
    start = effective_items;
    while (effective_items - start < target) begin
      choice = $urandom_range(99);
      if (choice < 55) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 6);
        frames = (len > 6) ? $urandom_range(1, 6) : (len == 0 ? 1 : len);
        // now and then a batch runs over or under its stated length
        if ($urandom_range(4) == 0) frames = frames + $urandom_range(2) - 1;
        if (frames < 1) frames = 1;
        send_push(1'b1, 13'(len), random_sample(), random_sample());
        for (k = 1; k < frames; k++)
          send_push(1'b0, 13'($urandom), random_sample(), random_sample());
      end else if (choice < 90) begin
        send_pull(($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                           : 7'($urandom_range(1, 12)));
      end else begin
        send_push(1'b0, 13'($urandom), random_sample(), random_sample());
      end
    end
    drain();
  endtask

  // Hold the output side off while pulls keep coming so the input backs up.
  task automatic test_backpressure();
    int k;
    send_push(1'b1, 13'd10, random_sample(), random_sample());
    for (k = 1; k < 10; k++) send_push(1'b0, 13'd0, random_sample(), random_sample());
    hold_asked <= hold_asked + 1;
    for (k = 0; k < 6; k++) begin
      send_pull(7'd3);
      send_push(1'b1, 13'd1, random_sample(), random_sample());
    end
    drain();
  endtask

  // receiver side: random stall, or a long counted hold when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      hold_granted <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: left_out %0d right_out %0d", left_out, right_out);
        fail_count++;
      end else begin
        e = expected_frames.pop_front();
        frames_checked++;
        if (e.pad) padded_checked++;
        if (left_out !== e.left) begin
          $error("left_out: expected %0d, got %0d", e.left, left_out);
          fail_count++;
        end
        if (right_out !== e.right) begin
          $error("right_out: expected %0d, got %0d", e.right, right_out);
          fail_count++;
        end
        if (padded !== e.pad) begin
          $error("padded: expected %0d, got %0d", e.pad, padded);
          fail_count++;
        end
        if (last !== e.fin) begin
          $error("last: expected %0d, got %0d", e.fin, last);
          fail_count++;
        end
        if (delivered_frames !== e.delivered) begin
          $error("delivered_frames: expected %0d, got %0d", e.delivered, delivered_frames);
          fail_count++;
        end
        if (underrun_count !== e.underruns) begin
          $error("underrun_count: expected %0d, got %0d", e.underruns, underrun_count);
          fail_count++;
        end
        if (fill_frames !== e.fill) begin
          $error("fill_frames: expected %0d, got %0d", e.fill, fill_frames);
          fail_count++;
        end
      end
    end
  end

  // watchdog: count cycles with no request or frame moving
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $error("no handshake for %0d cycles", IDLE_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    foreach (ring[i]) ring[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(0, 0);
    test_reset_padding();
    test_saturation_and_batches();
    test_short_store();
    set_idling(0, 0);
    random_traffic(10);
    set_idling(88, 0);
    random_traffic(10);
    set_idling(0, 88);
    random_traffic(10);
    set_idling(33, 33);
    random_traffic(10);
    set_idling(0, 0);
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $error("%0d expected frames never arrived", expected_frames.size());
      fail_count++;
    end
    $display("Ran %0d pull requests, checked %0d frames (%0d padded), %0d underruns,",
             pulls_sent, frames_checked, padded_checked, underruns);
    $display("with saturation, refused batches and input held off for %0d cycles.",
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ssf_pkg.sv
rtl/core/ssf_front.sv
rtl/core/ssf_queue.sv
rtl/core/ssf_back.sv
rtl/core/stereo_sample_fifo_with_underrun_pad_core.sv
bench/tb.sv
